>>> rtl/core/olpd_pkg.sv
// olpd_pkg: shared types and constants for the ordered list block
// (payload structs, opcodes, status codes, cell control)
// no dependencies
package olpd_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_ENTRY     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] item;
        logic                     last;
    } t_out_item;

    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_PUSH   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_ROTATE = 2'd3
    } t_cell_act;

    typedef struct packed {
        t_cell_act act;
        logic      occ;
        logic      tail;
    } t_cell_ctrl;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_DUMP = 1'b1
    } t_state;

endpackage

>>> rtl/core/olpd_cell.sv
// olpd_cell: one list slot; shifts, closes gaps and rotates with its neighbors
// uses olpd_pkg for the cell control struct and data width
module olpd_cell (
    input  logic                                 i_clk,
    input  olpd_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [olpd_pkg::DATA_W-1:0]          i_key,
    input  logic [olpd_pkg::DATA_W-1:0]          i_prev_data,
    input  logic [olpd_pkg::DATA_W-1:0]          i_next_data,
    input  logic [olpd_pkg::DATA_W-1:0]          i_head_data,
    input  logic                                 i_found,
    output logic                                 o_found,
    output logic [olpd_pkg::DATA_W-1:0]          o_data
);

    logic [olpd_pkg::DATA_W-1:0] r_data;
    logic [olpd_pkg::DATA_W-1:0] n_data;
    logic                        w_match;

    assign w_match = i_ctrl.occ && (r_data == i_key);
    // found flag ripples toward the tail: set at and after the newest match
    assign o_found = i_found | w_match;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.act)
            olpd_pkg::ACT_PUSH: begin
                n_data = i_prev_data;
            end
            olpd_pkg::ACT_DELETE: begin
                if (o_found) begin
                    n_data = i_next_data;
                end
            end
            olpd_pkg::ACT_ROTATE: begin
                // tail wraps the head around, others move one toward the head
                n_data = i_ctrl.tail ? i_head_data : i_next_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> rtl/core/ordered_list_push_delete_dump.sv
// ordered_list_push_delete_dump: bounded newest-first list built as a chain of cells
// uses olpd_pkg and olpd_cell
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes commands:
//   push, delete first match, dump. Output channel (o_out_valid / i_out_stall
//   / o_out_item) returns results; the final result of each command has last
//   set. Opcode 3 is taken and gives no result.
//   Push and delete act on all cells at once: the result is registered at
//   the transfer, and a new command may follow every cycle as long as the
//   receiver takes results.
//   A dump of N > 0 entries gives N results, one per cycle while the receiver
//   takes them, by rotating the chain N times toward the head; the input is
//   stalled until the rotation is done. An empty dump gives one EMPTY result.
//   Delete search is one compare per cell plus a found flag rippling along
//   the DEPTH cells.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result. While the receiver stalls, the result register holds and the
//   input is stalled; a dump pauses in place.
module ordered_list_push_delete_dump #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  olpd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output olpd_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);

    olpd_pkg::t_state     r_state;
    olpd_pkg::t_state     n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_remain;
    logic [CW-1:0]        n_remain;
    logic                 r_out_valid;
    logic                 n_out_valid;
    olpd_pkg::t_out_item  r_out;
    olpd_pkg::t_out_item  n_out;
    olpd_pkg::t_cell_act  w_act;

    logic                              w_out_free;
    logic                              w_in_xfer;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_hit;
    olpd_pkg::t_op                     w_op;
    logic [olpd_pkg::DATA_W-1:0]       w_data  [DEPTH];
    logic                              w_found [DEPTH];
    olpd_pkg::t_cell_ctrl              w_ctrl  [DEPTH];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != olpd_pkg::FSM_IDLE) || !w_out_free;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_hit      = w_found[DEPTH-1];
    assign w_op       = olpd_pkg::t_op'(i_in_item.opcode);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [olpd_pkg::DATA_W-1:0] w_prev;
            logic [olpd_pkg::DATA_W-1:0] w_next;
            logic                        w_fin;

            assign w_ctrl[g].act  = w_act;
            assign w_ctrl[g].occ  = (CW'(g) < r_count);
            assign w_ctrl[g].tail = (CW'(g + 1) == r_count);

            if (g == 0) begin : g_head
                assign w_prev = i_in_item.value;
                assign w_fin  = 1'b0;
            end else begin : g_body
                assign w_prev = w_data[g-1];
                assign w_fin  = w_found[g-1];
            end

            if (g == DEPTH - 1) begin : g_end
                assign w_next = w_data[g];
            end else begin : g_mid
                assign w_next = w_data[g+1];
            end

            olpd_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[g]),
                .i_key       (i_in_item.value),
                .i_prev_data (w_prev),
                .i_next_data (w_next),
                .i_head_data (w_data[0]),
                .i_found     (w_fin),
                .o_found     (w_found[g]),
                .o_data      (w_data[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olpd_pkg::FSM_IDLE: begin
                if (w_in_xfer && (w_op == olpd_pkg::OP_DUMP) && !w_empty) begin
                    n_state = olpd_pkg::FSM_DUMP;
                end
            end
            olpd_pkg::FSM_DUMP: begin
                if (w_out_free && (r_remain == CW'(1))) begin
                    n_state = olpd_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = olpd_pkg::FSM_IDLE;
            end
        endcase
    end

    // outputs, cell actions and counters
    always_comb begin
        n_count     = r_count;
        n_remain    = r_remain;
        w_act       = olpd_pkg::ACT_HOLD;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            olpd_pkg::FSM_IDLE: begin
                if (w_in_xfer) begin
                    n_out.item = '0;
                    n_out.last = 1'b1;
                    case (w_op)
                        olpd_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out.status = olpd_pkg::ST_FULL;
                            end else begin
                                w_act        = olpd_pkg::ACT_PUSH;
                                n_count      = r_count + CW'(1);
                                n_out.status = olpd_pkg::ST_PUSHED;
                            end
                        end
                        olpd_pkg::OP_DELETE: begin
                            n_out_valid = 1'b1;
                            if (w_empty) begin
                                n_out.status = olpd_pkg::ST_EMPTY;
                            end else if (w_hit) begin
                                w_act        = olpd_pkg::ACT_DELETE;
                                n_count      = r_count - CW'(1);
                                n_out.status = olpd_pkg::ST_DELETED;
                            end else begin
                                n_out.status = olpd_pkg::ST_NOT_FOUND;
                            end
                        end
                        olpd_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out.status = olpd_pkg::ST_EMPTY;
                            end else begin
                                n_remain = r_count;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    endcase
                end
            end
            olpd_pkg::FSM_DUMP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = olpd_pkg::ST_ENTRY;
                    n_out.item   = w_data[0];
                    n_out.last   = (r_remain == CW'(1));
                    w_act        = olpd_pkg::ACT_ROTATE;
                    n_remain     = r_remain - CW'(1);
                end
            end
            default: begin
                w_act = olpd_pkg::ACT_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olpd_pkg::FSM_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    a_dump_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olpd_pkg::FSM_DUMP) |-> (r_remain != '0))
        else $error("dump running with nothing left");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_op == olpd_pkg::OP_PUSH) && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the list");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == olpd_pkg::FSM_DUMP) && w_out_free && (r_remain == CW'(1)))
        |=> ((r_state == olpd_pkg::FSM_IDLE) && r_out_valid && r_out.last))
        else $error("dump did not close with a last transfer");
`endif

endmodule
